// ===== src/capm_pkg.sv =====
// ----------------------------------------------------------------------------
// capm_pkg
// Shared types and constants for the cascaded attitude PID and motor mixer.
// ----------------------------------------------------------------------------
package capm_pkg;

    localparam int NUM_AXES    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    typedef enum logic [2:0] {
        REG_OUTER_KP   = 3'd0,
        REG_OUTER_KI   = 3'd1,
        REG_INNER_KP   = 3'd2,
        REG_INNER_KI   = 3'd3,
        REG_INNER_KD   = 3'd4,
        REG_TILT       = 3'd5,
        REG_INT_LIMIT  = 3'd6,
        REG_STEP       = 3'd7
    } cfg_idx_t;

    // Sequencer phases: one axis lane runs its chain over these steps.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_P0,
        PH_P1,
        PH_P2,
        PH_P3,
        PH_P4,
        PH_P5,
        PH_P6,
        PH_P7,
        PH_P8,
        PH_MIX,
        PH_OUT
    } phase_t;

    // Per-axis gains handed to one lane.
    typedef struct packed {
        logic [15:0] okp;
        logic [15:0] oki;
        logic [15:0] ikp;
        logic [15:0] iki;
        logic [15:0] ikd;
    } lane_gain_t;

    typedef struct packed {
        logic start;
        phase_t phase;
    } lane_ctl_t;

    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        if (v > 24'sd524287)
            return 20'sd524287;
        else if (v < -24'sd524288)
            return -20'sd524288;
        else
            return v[19:0];
    endfunction

endpackage

// ===== src/capm_lane.sv =====
// ----------------------------------------------------------------------------
// capm_lane
// One axis: outer angle PI and inner rate PID, one multiply per step.
// ----------------------------------------------------------------------------
module capm_lane
    import capm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctl_t           ctl,
    input  lane_gain_t          gain,
    input  logic [15:0]         step,
    input  logic [30:0]         int_limit,
    input  logic signed [15:0]  set_angle,
    input  logic signed [15:0]  meas_angle,
    input  logic signed [15:0]  meas_rate,
    output logic signed [39:0]  effort
);

    logic signed [31:0] ang_int_reg, ang_int_next;
    logic signed [31:0] rate_int_reg, rate_int_next;
    logic signed [23:0] last_er_reg, last_er_next;
    logic signed [16:0] ea_reg, ea_next;
    logic signed [23:0] er_reg, er_next;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [32:0] sk_reg, sk_next;
    logic signed [58:0] prod_reg;
    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [58:0] prod;
    logic signed [24:0] dsum;
    logic signed [47:0] lim_pos;
    logic signed [47:0] ai_sum, ri_sum;
    logic signed [47:0] demand;
    logic signed [39:0] dem_sh;
    logic signed [40:0] er_raw;

    assign prod = mul_a * mul_b;
    assign lim_pos = 48'(int_limit);
    assign ai_sum = 48'(ang_int_reg) + 48'(prod_reg >>> 8);
    assign ri_sum = 48'(rate_int_reg) + 48'(prod_reg >>> 8);
    assign demand = acc_reg + 48'(prod_reg >>> 8);
    assign dem_sh = 40'(demand >>> 8);
    assign er_raw = 41'(dem_sh) - 41'(meas_rate);
    assign dsum = 25'(er_reg) - 25'(last_er_reg);

    // operand select per phase; each product is registered and used in the next phase
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.phase)
            PH_P0: begin mul_a = 33'(ea_next); mul_b = 26'(step); end
            PH_P1: begin mul_a = 33'(ea_reg); mul_b = 26'(gain.okp); end
            PH_P2: begin mul_a = 33'(ang_int_reg); mul_b = 26'(gain.oki); end
            PH_P3: begin mul_a = $signed(33'(step)); mul_b = 26'(gain.ikd); end
            PH_P4: begin mul_a = 33'(er_reg); mul_b = 26'(step); end
            PH_P5: begin mul_a = 33'(er_reg); mul_b = 26'(gain.ikp); end
            PH_P6: begin mul_a = 33'(rate_int_reg); mul_b = 26'(gain.iki); end
            PH_P7: begin mul_a = sk_reg; mul_b = 26'(dsum); end
            default: ;
        endcase
    end

    always_comb
    begin
        ang_int_next  = ang_int_reg;
        rate_int_next = rate_int_reg;
        last_er_next  = last_er_reg;
        ea_next       = ea_reg;
        er_next       = er_reg;
        acc_next      = acc_reg;
        sk_next       = sk_reg;
        if (ctl.start)
            ea_next = 17'(set_angle) - 17'(meas_angle);
        case (ctl.phase)
            PH_P1:
            begin
                // prod_reg holds ea*step
                if (ai_sum > lim_pos || ai_sum < -lim_pos)
                    ang_int_next = '0;
                else
                    ang_int_next = ai_sum[31:0];
            end
            PH_P2: acc_next = 48'(prod_reg);
            PH_P3:
            begin
                // demand = Kp*ea + Ki*I/256, rate error saturated to 24 bits
                if (er_raw > 41'sd8388607)
                    er_next = 24'sd8388607;
                else if (er_raw < -41'sd8388608)
                    er_next = -24'sd8388608;
                else
                    er_next = er_raw[23:0];
            end
            PH_P4: sk_next = prod_reg[32:0];
            PH_P5:
            begin
                if (ri_sum > lim_pos || ri_sum < -lim_pos)
                    rate_int_next = '0;
                else
                    rate_int_next = ri_sum[31:0];
            end
            PH_P6: acc_next = 48'(prod_reg);
            PH_P7:
            begin
                acc_next = acc_reg + 48'(prod_reg >>> 8);
                last_er_next = er_reg;
            end
            PH_P8: acc_next = acc_reg + 48'(prod_reg >>> 15);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_int_reg  <= '0;
            rate_int_reg <= '0;
            last_er_reg  <= '0;
        end
        else
        begin
            ang_int_reg  <= ang_int_next;
            rate_int_reg <= rate_int_next;
            last_er_reg  <= last_er_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg   <= ea_next;
        er_reg   <= er_next;
        acc_reg  <= acc_next;
        sk_reg   <= sk_next;
        prod_reg <= prod;
    end

    assign effort = 40'(acc_reg >>> 8);

endmodule

// ===== src/capm_mixer.sv =====
// ----------------------------------------------------------------------------
// capm_mixer
// X-frame mix of throttle and three axis efforts, saturated to 20 bits.
// ----------------------------------------------------------------------------
module capm_mixer
    import capm_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic signed [15:0]  throttle,
    input  logic signed [39:0]  eff_roll,
    input  logic signed [39:0]  eff_pitch,
    input  logic signed [39:0]  eff_yaw,
    output logic signed [19:0]  m0,
    output logic signed [19:0]  m1,
    output logic signed [19:0]  m2,
    output logic signed [19:0]  m3
);

    logic signed [41:0] s0, s1, s2, s3, t;
    logic signed [19:0] m0_reg, m1_reg, m2_reg, m3_reg;

    assign t  = 42'(throttle);
    assign s0 = t + 42'(eff_roll) - 42'(eff_pitch) + 42'(eff_yaw);
    assign s1 = t - 42'(eff_roll) - 42'(eff_pitch) - 42'(eff_yaw);
    assign s2 = t - 42'(eff_roll) + 42'(eff_pitch) + 42'(eff_yaw);
    assign s3 = t + 42'(eff_roll) + 42'(eff_pitch) - 42'(eff_yaw);

    function automatic logic signed [19:0] sat42(input logic signed [41:0] v);
        if (v > 42'sd524287)
            return 20'sd524287;
        else if (v < -42'sd524288)
            return -20'sd524288;
        else
            return sat20(v[23:0]);
    endfunction

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m0_reg <= sat42(s0);
            m1_reg <= sat42(s1);
            m2_reg <= sat42(s2);
            m3_reg <= sat42(s3);
        end
    end

    assign m0 = m0_reg;
    assign m1 = m1_reg;
    assign m2 = m2_reg;
    assign m3 = m3_reg;

endmodule

// ===== src/cascaded_attitude_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// cascaded_attitude_pid_mixer
// Cascaded angle/rate PID on three axes with X quadcopter motor mixing.
// ----------------------------------------------------------------------------
// One tick is taken, then three axis lanes run side by side through a
// shared phase sequencer of nine steps (eight multiplies and a final
// accumulate), each lane owning one 33x26 multiplier; the mixer then
// registers the four motor commands. The result is valid in the output
// phase that follows the mix, and the next item is taken in the cycle
// after the result has been transferred, so no new tick is taken while
// one is in flight, and an output stall holds the next one off.
module cascaded_attitude_pid_mixer
    import capm_pkg::*;
#(
    parameter int AXES = NUM_AXES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [15:0]         throttle,
    input  logic signed [15:0]         set_roll,
    input  logic signed [15:0]         set_pitch,
    input  logic signed [15:0]         set_yaw,
    input  logic signed [15:0]         meas_roll,
    input  logic signed [15:0]         meas_pitch,
    input  logic signed [15:0]         meas_yaw,
    input  logic signed [15:0]         rate_roll,
    input  logic signed [15:0]         rate_pitch,
    input  logic signed [15:0]         rate_yaw,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [19:0]         motor_front_a,
    output logic signed [19:0]         motor_front_b,
    output logic signed [19:0]         motor_rear_a,
    output logic signed [19:0]         motor_rear_b
);

    logic [47:0] okp_reg, oki_reg, ikp_reg, iki_reg, ikd_reg;
    logic [31:0] tilt_reg;
    logic [30:0] ilim_reg;
    logic [15:0] step_reg;
    phase_t      phase_reg, phase_next;
    logic        in_xfer;
    lane_ctl_t   ctl;

    logic signed [15:0] thr_reg;
    logic signed [15:0] set_reg  [AXES];
    logic signed [15:0] meas_reg [AXES];
    logic signed [15:0] rate_reg [AXES];
    logic signed [15:0] set_in   [AXES];
    logic signed [15:0] meas_in  [AXES];
    logic signed [15:0] rate_in  [AXES];
    logic signed [39:0] eff      [AXES];

    assign in_stall = (phase_reg != PH_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = (phase_reg == PH_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            okp_reg  <= '0;
            oki_reg  <= '0;
            ikp_reg  <= '0;
            iki_reg  <= '0;
            ikd_reg  <= '0;
            tilt_reg <= '0;
            ilim_reg <= 31'h7FFFFFFF;
            step_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_OUTER_KP:  okp_reg  <= cfg_data;
                REG_OUTER_KI:  oki_reg  <= cfg_data;
                REG_INNER_KP:  ikp_reg  <= cfg_data;
                REG_INNER_KI:  iki_reg  <= cfg_data;
                REG_INNER_KD:  ikd_reg  <= cfg_data;
                REG_TILT:      tilt_reg <= cfg_data[31:0];
                REG_INT_LIMIT: ilim_reg <= cfg_data[30:0];
                REG_STEP:      step_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: if (in_xfer) phase_next = PH_P0;
            PH_P0:   phase_next = PH_P1;
            PH_P1:   phase_next = PH_P2;
            PH_P2:   phase_next = PH_P3;
            PH_P3:   phase_next = PH_P4;
            PH_P4:   phase_next = PH_P5;
            PH_P5:   phase_next = PH_P6;
            PH_P6:   phase_next = PH_P7;
            PH_P7:   phase_next = PH_P8;
            PH_P8:   phase_next = PH_MIX;
            PH_MIX:  phase_next = PH_OUT;
            PH_OUT:  if (!out_stall) phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // capture the tick; tilt caps on roll and pitch
    assign set_in[0]  = (set_roll > $signed(tilt_reg[15:0])) ? $signed(tilt_reg[15:0])
                                                             : set_roll;
    assign set_in[1]  = (set_pitch > $signed(tilt_reg[31:16])) ? $signed(tilt_reg[31:16])
                                                               : set_pitch;
    assign set_in[2]  = set_yaw;
    assign meas_in[0] = meas_roll;
    assign meas_in[1] = meas_pitch;
    assign meas_in[2] = meas_yaw;
    assign rate_in[0] = rate_roll;
    assign rate_in[1] = rate_pitch;
    assign rate_in[2] = rate_yaw;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            thr_reg <= throttle;
            for (int i = 0; i < AXES; i++)
            begin
                set_reg[i]  <= set_in[i];
                meas_reg[i] <= meas_in[i];
                rate_reg[i] <= rate_in[i];
            end
        end
    end

    assign ctl.start = (phase_reg == PH_P0);
    assign ctl.phase = phase_reg;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        lane_gain_t gsel;
        assign gsel.okp = okp_reg[16*g +: 16];
        assign gsel.oki = oki_reg[16*g +: 16];
        assign gsel.ikp = ikp_reg[16*g +: 16];
        assign gsel.iki = iki_reg[16*g +: 16];
        assign gsel.ikd = ikd_reg[16*g +: 16];

        capm_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .gain       (gsel),
            .step       (step_reg),
            .int_limit  (ilim_reg),
            .set_angle  (set_reg[g]),
            .meas_angle (meas_reg[g]),
            .meas_rate  (rate_reg[g]),
            .effort     (eff[g])
        );
    end

    capm_mixer u_mix (
        .clk       (clk),
        .load      (phase_reg == PH_MIX),
        .throttle  (thr_reg),
        .eff_roll  (eff[0]),
        .eff_pitch (eff[1]),
        .eff_yaw   (eff[2]),
        .m0        (motor_front_a),
        .m1        (motor_front_b),
        .m2        (motor_rear_a),
        .m3        (motor_rear_b)
    );

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> in_stall)
        else $error("input not stalled while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(motor_front_a)))
        else $error("result changed under stall");
    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (phase_reg == PH_P0))
        else $error("sequencer did not start");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cascaded attitude PID and motor mixer against an in-bench
// fixed-point model of the angle and rate loops. The gains, tilt caps,
// integral bound and step go through several settings, extremes included.
// The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    import capm_pkg::*;

    typedef struct {
        logic signed [15:0] thr;
        logic signed [15:0] set_v [3];
        logic signed [15:0] meas_v [3];
        logic signed [15:0] rate_v [3];
    } tick_t;

    typedef struct {
        logic signed [19:0] m [4];
    } motors_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] throttle = '0;
    logic signed [15:0] set_roll = '0, set_pitch = '0, set_yaw = '0;
    logic signed [15:0] meas_roll = '0, meas_pitch = '0, meas_yaw = '0;
    logic signed [15:0] rate_roll = '0, rate_pitch = '0, rate_yaw = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [19:0] motor_front_a, motor_front_b, motor_rear_a, motor_rear_b;

    cascaded_attitude_pid_mixer uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the register file and loop state
    logic [47:0] regs [8];
    longint angle_int [3];
    longint rate_int [3];
    longint last_err [3];

    tick_t ticks_pending [$];
    motors_t motors_due [$];
    tick_t cur_tick;
    bit hold_tx = 0;
    int errors = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint bound_int(longint v);
        longint lim;
        lim = longint'(regs[REG_INT_LIMIT][30:0]);
        return (v > lim || v < -lim) ? 0 : v;
    endfunction

    function automatic motors_t attitude_tick(tick_t t);
        motors_t r;
        longint step, sp, ea, dem, er, e, kpo, kio, kpi, kii, kdi;
        longint eff [3];
        longint mix [4];
        step = longint'(regs[REG_STEP][15:0]);
        for (int i = 0; i < 3; i++)
        begin
            sp = longint'(t.set_v[i]);
            if (i == 0 && sp > longint'($signed(regs[REG_TILT][15:0])))
                sp = longint'($signed(regs[REG_TILT][15:0]));
            if (i == 1 && sp > longint'($signed(regs[REG_TILT][31:16])))
                sp = longint'($signed(regs[REG_TILT][31:16]));
            kpo = longint'(regs[REG_OUTER_KP][16*i +: 16]);
            kio = longint'(regs[REG_OUTER_KI][16*i +: 16]);
            kpi = longint'(regs[REG_INNER_KP][16*i +: 16]);
            kii = longint'(regs[REG_INNER_KI][16*i +: 16]);
            kdi = longint'(regs[REG_INNER_KD][16*i +: 16]);
            ea = sp - longint'(t.meas_v[i]);
            angle_int[i] = bound_int(angle_int[i] + ((ea * step) >>> 8));
            dem = kpo * ea + ((kio * angle_int[i]) >>> 8);
            er = clamp((dem >>> 8) - longint'(t.rate_v[i]), -8388608, 8388607);
            rate_int[i] = bound_int(rate_int[i] + ((er * step) >>> 8));
            e = kpi * er + ((kii * rate_int[i]) >>> 8)
              + ((kdi * (er - last_err[i]) * step) >>> 15);
            last_err[i] = er;
            eff[i] = e >>> 8;
        end
        mix[0] = longint'(t.thr) + eff[0] - eff[1] + eff[2];
        mix[1] = longint'(t.thr) - eff[0] - eff[1] - eff[2];
        mix[2] = longint'(t.thr) - eff[0] + eff[1] + eff[2];
        mix[3] = longint'(t.thr) + eff[0] + eff[1] - eff[2];
        for (int k = 0; k < 4; k++)
            r.m[k] = 20'(clamp(mix[k], -524288, 524287));
        return r;
    endfunction

    // sender: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                motors_due.push_back(attitude_tick(cur_tick));
                ticks_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (hold_tx || ticks_pending.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_tick = ticks_pending.pop_front();
                    throttle <= cur_tick.thr;
                    set_roll <= cur_tick.set_v[0];
                    set_pitch <= cur_tick.set_v[1];
                    set_yaw <= cur_tick.set_v[2];
                    meas_roll <= cur_tick.meas_v[0];
                    meas_pitch <= cur_tick.meas_v[1];
                    meas_yaw <= cur_tick.meas_v[2];
                    rate_roll <= cur_tick.rate_v[0];
                    rate_pitch <= cur_tick.rate_v[1];
                    rate_yaw <= cur_tick.rate_v[2];
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 60);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // receiver stall pattern: modes of none, light and heavy stalling
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic check_field(string name, logic signed [19:0] want, logic signed [19:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // monitor and watchdog
    always @(posedge clk)
    begin
        motors_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (motors_due.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with nothing expected", $time);
            end
            else
            begin
                want = motors_due.pop_front();
                check_field("motor_front_a", want.m[0], motor_front_a);
                check_field("motor_front_b", want.m[1], motor_front_b);
                check_field("motor_rear_a", want.m[2], motor_rear_a);
                check_field("motor_rear_b", want.m[3], motor_rear_b);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (ticks_pending.size() == 0 && motors_due.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [47:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        regs[idx] = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [47:0] okp, logic [47:0] oki, logic [47:0] ikp,
                             logic [47:0] iki, logic [47:0] ikd, logic [31:0] tilt,
                             logic [30:0] lim, logic [15:0] step);
        write_reg(REG_OUTER_KP, okp);
        write_reg(REG_OUTER_KI, oki);
        write_reg(REG_INNER_KP, ikp);
        write_reg(REG_INNER_KI, iki);
        write_reg(REG_INNER_KD, ikd);
        write_reg(REG_TILT, {16'h0, tilt});
        write_reg(REG_INT_LIMIT, {17'h0, lim});
        write_reg(REG_STEP, {32'h0, step});
    endtask

    function automatic logic signed [15:0] rand_q88();
        case ($urandom_range(0, 9))
            6, 7: return 16'($urandom);
            8: return 16'sh7FFF;
            9: return -16'sh8000;
            default: return 16'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.thr = rand_q88();
        for (int i = 0; i < 3; i++)
        begin
            t.set_v[i] = rand_q88();
            t.meas_v[i] = rand_q88();
            t.rate_v[i] = rand_q88();
        end
        return t;
    endfunction

    function automatic tick_t flat_tick(logic signed [15:0] thr, logic signed [15:0] s,
                                        logic signed [15:0] m, logic signed [15:0] r);
        tick_t t;
        t.thr = thr;
        for (int i = 0; i < 3; i++)
        begin
            t.set_v[i] = s;
            t.meas_v[i] = m;
            t.rate_v[i] = r;
        end
        return t;
    endfunction

    function automatic logic [47:0] rand_gains(int hi);
        return {16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
                16'($urandom_range(0, hi))};
    endfunction

    task automatic drain();
        wait (ticks_pending.size() == 0 && motors_due.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++)
            ticks_pending.push_back(rand_tick());
    endtask

    initial
    begin
        tick_t t;
        for (int i = 0; i < 8; i++)
            regs[i] = '0;
        regs[REG_INT_LIMIT] = 48'h7FFF_FFFF;
        for (int i = 0; i < 3; i++)
        begin
            angle_int[i] = 0;
            rate_int[i] = 0;
            last_err[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // a few ticks on reset values: efforts are zero
        ticks_pending.push_back(flat_tick(16'sh7FFF, 16'sh1234, -16'sh0100, 16'sh0050));
        ticks_pending.push_back(flat_tick(-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF));
        drain();

        // directed: moderate gains, roll cap 10 deg, pitch cap -10 deg, tight bound
        write_all({3{16'h0100}}, {3{16'h0080}}, {3{16'h0200}}, {3{16'h0040}},
                  {3{16'h0100}}, 32'hF600_0A00, 31'h0002_0000, 16'h0100);
        ticks_pending.push_back(flat_tick(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000));
        ticks_pending.push_back(flat_tick(-16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh1000, 16'sh7FFF, 16'sh0000, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh1000, -16'sh8000, 16'sh0000, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh1000, 16'sh0000, 16'sh7FFF, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh1000, 16'sh0000, -16'sh8000, 16'sh0000));
        ticks_pending.push_back(flat_tick(16'sh1000, 16'sh0000, 16'sh0000, 16'sh7FFF));
        ticks_pending.push_back(flat_tick(16'sh1000, 16'sh0000, 16'sh0000, -16'sh8000));
        ticks_pending.push_back(flat_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        ticks_pending.push_back(flat_tick(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000));
        // roll just above its cap, pitch just below its cap
        t = flat_tick(16'sh0800, 16'sh0000, 16'sh0000, 16'sh0000);
        t.set_v[0] = 16'sh0A01;
        t.set_v[1] = -16'sh0A01;
        t.set_v[2] = 16'sh7FFF;
        ticks_pending.push_back(t);
        // large yaw error repeated so the integrators cross the bound
        t.set_v[2] = 16'sh7FFF;
        t.meas_v[2] = -16'sh8000;
        repeat (4) ticks_pending.push_back(t);
        t.set_v[2] = -16'sh8000;
        t.meas_v[2] = 16'sh7FFF;
        repeat (4) ticks_pending.push_back(t);
        run_random(200);
        // hold the sender until everything in flight has come back
        wait (ticks_pending.size() == 0);
        hold_tx = 1;
        wait (motors_due.size() == 0 && !in_valid);
        hold_tx = 0;
        run_random(200);
        drain();

        // every register at its maximum
        write_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                  32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
        run_random(220);
        drain();

        // every register at its minimum
        write_all('0, '0, '0, '0, '0, 32'h8000_8000, 31'h0, 16'h0);
        run_random(220);
        drain();

        // gains on but zero step: integrators and derivative stay idle
        write_all(rand_gains(1024), rand_gains(1024), rand_gains(1024), rand_gains(1024),
                  rand_gains(1024), 32'h7FFF_7FFF, 31'h7FFF_FFFF, 16'h0);
        run_random(220);
        drain();

        // modest random gains with a small bound
        write_all(rand_gains(768), rand_gains(512), rand_gains(768), rand_gains(512),
                  rand_gains(1024), 32'($urandom), 31'($urandom_range(1, 1 << 20)),
                  16'($urandom_range(1, 4096)));
        run_random(240);
        drain();

        // fully random settings
        write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 32'($urandom), 31'($urandom), 16'($urandom));
        run_random(240);
        drain();

        // back to moderate values, wide bound
        write_all(rand_gains(512), rand_gains(256), rand_gains(512), rand_gains(256),
                  rand_gains(512), 32'h1E00_1E00, 31'h7FFF_FFFF, 16'($urandom_range(1, 65535)));
        run_random(240);
        drain();

        $display("covered %0d control ticks and %0d motor results over eight register settings,",
                 ticks_sent, results_seen);
        $display("from reset values through both extremes to random gains and bounds");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
